FILE: hdl/clamped_second_order_iir_rate_assert.svh
// assertion macros shared by the rate filter modules
`ifndef CLAMPED_SECOND_ORDER_IIR_RATE_ASSERT_SVH
`define CLAMPED_SECOND_ORDER_IIR_RATE_ASSERT_SVH
`ifndef SYNTHESIS
// check a property at every clock edge outside reset
`define CSOIR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("csoir assertion failed");
// check a property at every clock edge, reset included
`define CSOIR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("csoir assertion failed");
`else
`define CSOIR_ASSERT(label, clk, rst, prop)
`define CSOIR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: hdl/csoir_pkg.sv
// types, constants and register map of the clamped second-order rate filter
package csoir_pkg;

   // field widths
   localparam int FORCE_W = 16;
   localparam int RATE_W  = 24;
   localparam int COEF_W  = 32;

   // product and accumulator widths
   localparam int FF_PROD_W = COEF_W + FORCE_W;
   localparam int FF_SUM_W  = FF_PROD_W + 2;
   localparam int FB_PROD_W = COEF_W + RATE_W;
   localparam int ACC_W     = FB_PROD_W + 3;
   localparam int FRAC_DROP = 24;
   localparam int Q_W       = ACC_W - FRAC_DROP;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_FF_NOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FF_PREV     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FF_PPREV    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FB_PREV     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FB_PPREV    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SATURATION  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE    = 3'd7;

   localparam logic signed [FORCE_W-1:0] SATURATION_RESET = 16'sd32767;
   localparam logic signed [RATE_W-1:0]  SATURATED_RATE   = 24'sd25600;
   localparam logic signed [RATE_W-1:0]  RATE_MAX         = 24'sh7fffff;
   localparam logic signed [RATE_W-1:0]  RATE_MIN         = 24'sh800000;

   // rounding bias, half of the dropped fraction
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_DROP - 1);

   // item classes
   localparam int CLS_W = 2;
   localparam logic [CLS_W-1:0] CLS_FILTER   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_SATURATE = 2'd1;
   localparam logic [CLS_W-1:0] CLS_BASELINE = 2'd2;

   // queue depths
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 2;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   // configuration registers
   typedef struct packed {
      logic signed [COEF_W-1:0]  ff_gain_now;
      logic signed [COEF_W-1:0]  ff_gain_prev;
      logic signed [COEF_W-1:0]  ff_gain_pprev;
      logic signed [COEF_W-1:0]  fb_gain_prev;
      logic signed [COEF_W-1:0]  fb_gain_pprev;
      logic signed [FORCE_W-1:0] force_threshold;
      logic signed [FORCE_W-1:0] force_saturation;
      logic signed [RATE_W-1:0]  baseline_rate;
   } cfg_type;

   // classified item from the front to the back
   typedef struct packed {
      logic [CLS_W-1:0]           cls;
      logic signed [FF_SUM_W-1:0] ff_sum;
   } cmd_type;

endpackage

FILE: hdl/csoir_csr.sv
// configuration registers of the rate filter
module csoir_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [csoir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [csoir_pkg::CSR_DATA_W-1:0]    csr_data,
   output csoir_pkg::cfg_type                  cfg
);

   csoir_pkg::cfg_type cfg_ff;
   csoir_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            csoir_pkg::REG_FF_NOW:     cfg_in.ff_gain_now   = csr_data;
            csoir_pkg::REG_FF_PREV:    cfg_in.ff_gain_prev  = csr_data;
            csoir_pkg::REG_FF_PPREV:   cfg_in.ff_gain_pprev = csr_data;
            csoir_pkg::REG_FB_PREV:    cfg_in.fb_gain_prev  = csr_data;
            csoir_pkg::REG_FB_PPREV:   cfg_in.fb_gain_pprev = csr_data;
            csoir_pkg::REG_THRESHOLD:
               cfg_in.force_threshold = csr_data[csoir_pkg::FORCE_W-1:0];
            csoir_pkg::REG_SATURATION:
               cfg_in.force_saturation = csr_data[csoir_pkg::FORCE_W-1:0];
            csoir_pkg::REG_BASELINE:
               cfg_in.baseline_rate = csr_data[csoir_pkg::RATE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // registers with their reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ff_gain_now      <= '0;
         cfg_ff.ff_gain_prev     <= '0;
         cfg_ff.ff_gain_pprev    <= '0;
         cfg_ff.fb_gain_prev     <= '0;
         cfg_ff.fb_gain_pprev    <= '0;
         cfg_ff.force_threshold  <= '0;
         cfg_ff.force_saturation <= csoir_pkg::SATURATION_RESET;
         cfg_ff.baseline_rate    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/csoir_front.sv
// front end: force history, clamp classification and feedforward products
module csoir_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  csoir_pkg::cfg_type                     cfg,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [csoir_pkg::FORCE_W-1:0]   req_force_sample,
   output logic                                   cmd_push,
   input  logic                                   cmd_full,
   output csoir_pkg::cmd_type                     cmd_data
);

   logic signed [csoir_pkg::FORCE_W-1:0]   force_hist_one_ff;
   logic signed [csoir_pkg::FORCE_W-1:0]   force_hist_one_in;
   logic signed [csoir_pkg::FORCE_W-1:0]   force_hist_two_ff;
   logic signed [csoir_pkg::FORCE_W-1:0]   force_hist_two_in;
   logic signed [csoir_pkg::FF_PROD_W-1:0] prod_now;
   logic signed [csoir_pkg::FF_PROD_W-1:0] prod_prev;
   logic signed [csoir_pkg::FF_PROD_W-1:0] prod_pprev;

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   // feedforward products over the current and two past forces
   assign prod_now   = csoir_pkg::FF_PROD_W'(cfg.ff_gain_now)
                     * csoir_pkg::FF_PROD_W'(req_force_sample);
   assign prod_prev  = csoir_pkg::FF_PROD_W'(cfg.ff_gain_prev)
                     * csoir_pkg::FF_PROD_W'(force_hist_one_ff);
   assign prod_pprev = csoir_pkg::FF_PROD_W'(cfg.ff_gain_pprev)
                     * csoir_pkg::FF_PROD_W'(force_hist_two_ff);

   // feedforward sum and clamp classification, saturation wins over threshold
   always_comb begin
      cmd_data.ff_sum = csoir_pkg::FF_SUM_W'(prod_now)
                      + csoir_pkg::FF_SUM_W'(prod_prev)
                      + csoir_pkg::FF_SUM_W'(prod_pprev);
      if (req_force_sample >= cfg.force_saturation) begin
         cmd_data.cls = csoir_pkg::CLS_SATURATE;
      end else if (req_force_sample <= cfg.force_threshold) begin
         cmd_data.cls = csoir_pkg::CLS_BASELINE;
      end else begin
         cmd_data.cls = csoir_pkg::CLS_FILTER;
      end
   end

   // force history shifts on every accepted transaction
   always_comb begin
      force_hist_one_in = force_hist_one_ff;
      force_hist_two_in = force_hist_two_ff;
      if (cmd_push) begin
         force_hist_one_in = req_force_sample;
         force_hist_two_in = force_hist_one_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_hist_one_ff <= '0;
         force_hist_two_ff <= '0;
      end else begin
         force_hist_one_ff <= force_hist_one_in;
         force_hist_two_ff <= force_hist_two_in;
      end
   end

endmodule

FILE: hdl/csoir_cmd_queue.sv
// short queue of classified items between front and back
`include "clamped_second_order_iir_rate_assert.svh"
module csoir_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csoir_pkg::cmd_type   push_data,
   output logic                 full,
   input  logic                 pop,
   output csoir_pkg::cmd_type   pop_data,
   output logic                 empty
);

   csoir_pkg::cmd_type                   mem_ff [csoir_pkg::CMDQ_DEPTH];
   logic [csoir_pkg::CMDQ_PTR_W-1:0]     wr_ptr_ff;
   logic [csoir_pkg::CMDQ_PTR_W-1:0]     wr_ptr_in;
   logic [csoir_pkg::CMDQ_PTR_W-1:0]     rd_ptr_ff;
   logic [csoir_pkg::CMDQ_PTR_W-1:0]     rd_ptr_in;
   logic [csoir_pkg::CMDQ_CNT_W-1:0]     count_ff;
   logic [csoir_pkg::CMDQ_CNT_W-1:0]     count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign full     = (count_ff == csoir_pkg::CMDQ_CNT_W'(csoir_pkg::CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == csoir_pkg::CMDQ_PTR_W'(csoir_pkg::CMDQ_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == csoir_pkg::CMDQ_PTR_W'(csoir_pkg::CMDQ_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CSOIR_ASSERT(a_cmdq_count_bound, clock, reset,
      count_ff <= csoir_pkg::CMDQ_CNT_W'(csoir_pkg::CMDQ_DEPTH))
   `CSOIR_ASSERT(a_cmdq_empty_ptrs, clock, reset, empty |-> (wr_ptr_ff == rd_ptr_ff))
   `CSOIR_ASSERT(a_cmdq_push_grows, clock, reset,
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

FILE: hdl/csoir_back.sv
// back end: feedback products, rounding, clamping, rate history and result queue
`include "clamped_second_order_iir_rate_assert.svh"
module csoir_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  csoir_pkg::cfg_type                    cfg,
   input  csoir_pkg::cmd_type                    cmd_data,
   input  logic                                  cmd_empty,
   output logic                                  cmd_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [csoir_pkg::RATE_W-1:0]   rsp_spike_rate
);

   logic signed [csoir_pkg::RATE_W-1:0]     rate_hist_one_ff;
   logic signed [csoir_pkg::RATE_W-1:0]     rate_hist_one_in;
   logic signed [csoir_pkg::RATE_W-1:0]     rate_hist_two_ff;
   logic signed [csoir_pkg::RATE_W-1:0]     rate_hist_two_in;
   logic signed [csoir_pkg::FB_PROD_W-1:0]  prod_prev;
   logic signed [csoir_pkg::FB_PROD_W-1:0]  prod_pprev;
   logic signed [csoir_pkg::ACC_W-1:0]      acc;
   logic signed [csoir_pkg::ACC_W-1:0]      acc_rnd;
   logic signed [csoir_pkg::Q_W-1:0]        quo;
   logic signed [csoir_pkg::RATE_W-1:0]     filt_rate;
   logic signed [csoir_pkg::RATE_W-1:0]     rate;
   logic signed [csoir_pkg::RATE_W-1:0]     out_mem_ff [csoir_pkg::OUTQ_DEPTH];
   logic [csoir_pkg::OUTQ_PTR_W-1:0]        out_wr_ff;
   logic [csoir_pkg::OUTQ_PTR_W-1:0]        out_wr_in;
   logic [csoir_pkg::OUTQ_PTR_W-1:0]        out_rd_ff;
   logic [csoir_pkg::OUTQ_PTR_W-1:0]        out_rd_in;
   logic [csoir_pkg::OUTQ_CNT_W-1:0]        out_cnt_ff;
   logic [csoir_pkg::OUTQ_CNT_W-1:0]        out_cnt_in;
   logic                                    out_full;
   logic                                    out_pop;

   assign out_full = (out_cnt_ff == csoir_pkg::OUTQ_CNT_W'(csoir_pkg::OUTQ_DEPTH));
   assign cmd_pop  = !cmd_empty && !out_full;

   // feedback products over the two past rates
   assign prod_prev  = csoir_pkg::FB_PROD_W'(cfg.fb_gain_prev)
                     * csoir_pkg::FB_PROD_W'(rate_hist_one_ff);
   assign prod_pprev = csoir_pkg::FB_PROD_W'(cfg.fb_gain_pprev)
                     * csoir_pkg::FB_PROD_W'(rate_hist_two_ff);

   // full sum, round half up, drop the fraction
   assign acc     = csoir_pkg::ACC_W'(cmd_data.ff_sum)
                  - csoir_pkg::ACC_W'(prod_prev)
                  - csoir_pkg::ACC_W'(prod_pprev);
   assign acc_rnd = acc + csoir_pkg::ROUND_BIAS;
   assign quo     = acc_rnd[csoir_pkg::ACC_W-1:csoir_pkg::FRAC_DROP];

   // saturate to the rate range when the high bits disagree with the sign
   always_comb begin
      if (quo[csoir_pkg::Q_W-1:csoir_pkg::RATE_W-1] == '0
          || quo[csoir_pkg::Q_W-1:csoir_pkg::RATE_W-1] == '1) begin
         filt_rate = quo[csoir_pkg::RATE_W-1:0];
      end else if (quo[csoir_pkg::Q_W-1]) begin
         filt_rate = csoir_pkg::RATE_MIN;
      end else begin
         filt_rate = csoir_pkg::RATE_MAX;
      end
   end

   // result select by class
   always_comb begin
      unique case (cmd_data.cls)
         csoir_pkg::CLS_SATURATE: rate = csoir_pkg::SATURATED_RATE;
         csoir_pkg::CLS_BASELINE: rate = cfg.baseline_rate;
         csoir_pkg::CLS_FILTER:   rate = filt_rate;
         default:                 rate = filt_rate;
      endcase
   end

   // rate history takes every result, clamped ones too
   always_comb begin
      rate_hist_one_in = rate_hist_one_ff;
      rate_hist_two_in = rate_hist_two_ff;
      if (cmd_pop) begin
         rate_hist_one_in = rate;
         rate_hist_two_in = rate_hist_one_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_hist_one_ff <= '0;
         rate_hist_two_ff <= '0;
      end else begin
         rate_hist_one_ff <= rate_hist_one_in;
         rate_hist_two_ff <= rate_hist_two_in;
      end
   end

   // result queue
   assign rsp_empty      = (out_cnt_ff == '0);
   assign out_pop        = rsp_pop && !rsp_empty;
   assign rsp_spike_rate = out_mem_ff[out_rd_ff];

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (cmd_pop) begin
         out_wr_in = (out_wr_ff == csoir_pkg::OUTQ_PTR_W'(csoir_pkg::OUTQ_DEPTH - 1))
                   ? '0 : out_wr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == csoir_pkg::OUTQ_PTR_W'(csoir_pkg::OUTQ_DEPTH - 1))
                   ? '0 : out_rd_ff + 1'b1;
      end
      if (cmd_pop && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !cmd_pop) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         out_mem_ff[out_wr_ff] <= rate;
      end
   end

   `CSOIR_ASSERT(a_outq_count_bound, clock, reset,
      out_cnt_ff <= csoir_pkg::OUTQ_CNT_W'(csoir_pkg::OUTQ_DEPTH))
   `CSOIR_ASSERT(a_result_visible, clock, reset, cmd_pop |=> !rsp_empty)
   `CSOIR_ASSERT(a_rate_hist_shift, clock, reset,
      cmd_pop |=> (rate_hist_two_ff == $past(rate_hist_one_ff)))
   `CSOIR_ASSERT_ALWAYS(a_reset_clears_outq, clock,
      reset |=> (out_cnt_ff == '0))

endmodule

FILE: hdl/clamped_second_order_iir_rate.sv
// top level of the clamped second-order firing-rate filter
//
// Input channel: push a Q8.8 force on req_force_sample with req_push; the
// transaction is taken at a clock edge where req_full is low.
// Result channel: the oldest Q16.8 rate waits on rsp_spike_rate while
// rsp_empty is low; rsp_pop takes it. One rate comes out per force, in order.
// Config channel: csr_valid/csr_ready with csr_index and csr_data; write
// only while no transaction is in flight. csr_ready is always high.
// A force is registered in the command queue, its rate in the result queue.
// Throughput: one transaction per cycle while the result queue has room, set
// by the back end's recursion: the two feedback multiplies, the 59-bit sum,
// rounding and clamping of one rate all close before the next rate needs it.
// The front end classifies and forms the feedforward sum ahead of it,
// through a two-entry queue.
// Reset clears the force and rate histories and both queues, and loads the
// registers with their reset values (saturation force 32767, others zero).
// When the receiver stalls, the two-entry result queue fills, then the
// command queue, and req_full rises; nothing is lost.
module clamped_second_order_iir_rate (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [csoir_pkg::FORCE_W-1:0]  req_force_sample,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [csoir_pkg::RATE_W-1:0]   rsp_spike_rate,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csoir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [csoir_pkg::CSR_DATA_W-1:0]      csr_data
);

   csoir_pkg::cfg_type cfg;
   csoir_pkg::cmd_type cmd_wr_data;
   csoir_pkg::cmd_type cmd_rd_data;
   logic               cmd_push;
   logic               cmd_full;
   logic               cmd_pop;
   logic               cmd_empty;

   // configuration registers
   csoir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // classify and form the feedforward sum
   csoir_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_force_sample (req_force_sample),
      .cmd_push         (cmd_push),
      .cmd_full         (cmd_full),
      .cmd_data         (cmd_wr_data)
   );

   // decoupling queue
   csoir_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty)
   );

   // feedback, round, clamp and deliver
   csoir_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd_data       (cmd_rd_data),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_spike_rate (rsp_spike_rate)
   );

endmodule

FILE: sim/clamped_second_order_iir_rate_checker.sv
// checker for the rate filter: watches all channels, predicts each rate, compares in order
`timescale 1ns / 100ps

module clamped_second_order_iir_rate_checker
   import csoir_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic                        req_full,
   input  logic signed [FORCE_W-1:0]   req_force_sample,
   input  logic                        rsp_empty,
   input  logic                        rsp_pop,
   input  logic signed [RATE_W-1:0]    rsp_spike_rate,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   output int                          fail_count,
   output int                          rates_pending
);

   // shadow copy of the configuration registers
   logic signed [COEF_W-1:0]  gain_now, gain_prev, gain_pprev;
   logic signed [COEF_W-1:0]  fbk_prev, fbk_pprev;
   logic signed [FORCE_W-1:0] thr_level, sat_level;
   logic signed [RATE_W-1:0]  base_rate;

   // filter history
   logic signed [FORCE_W-1:0] force_d1, force_d2;
   logic signed [RATE_W-1:0]  rate_d1, rate_d2;

   logic signed [RATE_W-1:0]  expected_rates[$];
   int                        errors;

   // rate for one force: clamps first, else biquad sum rounded half up and saturated
   function automatic logic signed [RATE_W-1:0] filter_rate(input logic signed [FORCE_W-1:0] f);
      longint acc;
      longint q;
      if (f >= sat_level)
         return SATURATED_RATE;
      if (f <= thr_level)
         return base_rate;
      acc = longint'(gain_now) * longint'(f)
          + longint'(gain_prev) * longint'(force_d1)
          + longint'(gain_pprev) * longint'(force_d2)
          - longint'(fbk_prev) * longint'(rate_d1)
          - longint'(fbk_pprev) * longint'(rate_d2);
      q = (acc + (longint'(1) <<< 23)) >>> 24;
      if (q > longint'(RATE_MAX))
         q = longint'(RATE_MAX);
      else if (q < longint'(RATE_MIN))
         q = longint'(RATE_MIN);
      return q[RATE_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic signed [RATE_W-1:0] want;
      if (reset) begin
         gain_now   = '0;
         gain_prev  = '0;
         gain_pprev = '0;
         fbk_prev   = '0;
         fbk_pprev  = '0;
         thr_level  = '0;
         sat_level  = SATURATION_RESET;
         base_rate  = '0;
         force_d1   = '0;
         force_d2   = '0;
         rate_d1    = '0;
         rate_d2    = '0;
         expected_rates.delete();
         errors = 0;
      end else begin
         // result transaction against the oldest expected rate
         if (rsp_pop && !rsp_empty) begin
            if (expected_rates.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t: rate %0d popped with none expected", $time, rsp_spike_rate);
            end else begin
               want = expected_rates.pop_front();
               if (rsp_spike_rate !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%t: spike_rate mismatch, expected %0d got %0d",
                              $time, want, rsp_spike_rate);
               end
            end
         end

         // register write, upper bits beyond the register width dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FF_NOW:     gain_now   = csr_data;
               REG_FF_PREV:    gain_prev  = csr_data;
               REG_FF_PPREV:   gain_pprev = csr_data;
               REG_FB_PREV:    fbk_prev   = csr_data;
               REG_FB_PPREV:   fbk_pprev  = csr_data;
               REG_THRESHOLD:  thr_level  = csr_data[FORCE_W-1:0];
               REG_SATURATION: sat_level  = csr_data[FORCE_W-1:0];
               REG_BASELINE:   base_rate  = csr_data[RATE_W-1:0];
               default: ;
            endcase
         end

         // force transaction: predict and shift history, clamped rates included
         if (req_push && !req_full) begin
            want = filter_rate(req_force_sample);
            expected_rates.push_back(want);
            force_d2 = force_d1;
            force_d1 = req_force_sample;
            rate_d2  = rate_d1;
            rate_d1  = want;
         end
      end
      fail_count    <= errors;
      rates_pending <= expected_rates.size();
   end

endmodule

FILE: sim/clamped_second_order_iir_rate_test.sv
// testbench top for the rate filter: clock, reset, force and register stimulus, verdict
`timescale 1ns / 100ps

module clamped_second_order_iir_rate_test;
   import csoir_pkg::*;

   localparam int PHASE_ITEMS = 108;
   localparam int LONG_HOLD   = 300;

   logic                        clock;
   logic                        reset;
   logic                        req_push;
   logic                        req_full;
   logic signed [FORCE_W-1:0]   req_force_sample;
   logic                        rsp_empty;
   logic                        rsp_pop;
   logic signed [RATE_W-1:0]    rsp_spike_rate;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   int fail_count;
   int rates_pending;
   int sent_count;
   int popped_count;
   logic signed [FORCE_W-1:0] cur_thr, cur_sat;

   clamped_second_order_iir_rate DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_force_sample (req_force_sample),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_spike_rate   (rsp_spike_rate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   clamped_second_order_iir_rate_checker rate_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_force_sample (req_force_sample),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_spike_rate   (rsp_spike_rate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .rates_pending    (rates_pending)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("clamped_second_order_iir_rate verification failed");
      $finish;
   end

   // idle length: mostly none or short, a few long, plus stretches with none at all
   function automatic int pick_gap(input int n);
      int r;
      if (((n >> 5) % 3) == 1)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // random coefficient in [-span, span]
   function automatic logic signed [COEF_W-1:0] small_coef(input int span);
      return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // force: mostly inside the filter window, some on the clamp edges, some anywhere
   function automatic logic signed [FORCE_W-1:0] pick_force();
      int r;
      int lo, hi;
      r  = $urandom_range(0, 99);
      lo = int'(cur_thr) + 1;
      hi = int'(cur_sat) - 1;
      if (r < 70 && lo <= hi)
         return FORCE_W'(lo + int'($urandom_range(0, hi - lo)));
      if (r < 82) begin
         case ($urandom_range(0, 3))
            0: return cur_thr;
            1: return cur_thr + 16'sd1;
            2: return cur_sat;
            default: return cur_sat - 16'sd1;
         endcase
      end
      return FORCE_W'($urandom);
   endfunction

   // one force transaction, after a random idle gap
   task automatic send_force(input logic signed [FORCE_W-1:0] f);
      int gap;
      gap = pick_gap(sent_count);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_force_sample <= f;
      do @(posedge clock); while (req_full);
      sent_count++;
   endtask

   // one register write transaction; valid is lowered by the caller
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // stop pushing and wait until every rate has come back
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (rates_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // program all registers; unused upper data bits carry noise
   task automatic set_filter(input logic signed [COEF_W-1:0] c_now, c_prev, c_pprev,
                             input logic signed [COEF_W-1:0] r_prev, r_pprev,
                             input logic signed [FORCE_W-1:0] thr, sat,
                             input logic signed [RATE_W-1:0] base);
      wait_idle();
      write_reg(REG_FF_NOW,     c_now);
      write_reg(REG_FF_PREV,    c_prev);
      write_reg(REG_FF_PPREV,   c_pprev);
      write_reg(REG_FB_PREV,    r_prev);
      write_reg(REG_FB_PPREV,   r_pprev);
      write_reg(REG_THRESHOLD,  {16'($urandom), thr});
      write_reg(REG_SATURATION, {16'($urandom), sat});
      write_reg(REG_BASELINE,   {8'($urandom), base});
      csr_valid <= 1'b0;
      cur_thr = thr;
      cur_sat = sat;
      @(posedge clock);
   endtask

   // receiver: random pop gaps, with two long hold-offs while the sender keeps going
   initial begin : receiver
      int gap;
      rsp_pop <= 1'b0;
      popped_count = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap(popped_count + 16);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         popped_count++;
         if (popped_count == 80 || popped_count == 400) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      req_push         <= 1'b0;
      req_force_sample <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= REG_FF_NOW;
      csr_data         <= '0;
      reset            <= 1'b1;
      sent_count = 0;
      cur_thr    = '0;
      cur_sat    = SATURATION_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: saturation at the top force, zero filter below
      send_force(16'sh7fff);
      send_force(16'sh8000);
      send_force(16'sd0);
      send_force(16'sd1);

      // plain filter with both clamps on their exact boundaries
      set_filter(32'sh0100_0000, 32'sh0080_0000, -32'sh0040_0000,
                 32'sh0080_0000, -32'sh0040_0000, -16'sd1000, 16'sd20000, -24'sd500);
      send_force(16'sd20000);
      send_force(16'sd19999);
      send_force(-16'sd1000);
      send_force(-16'sd999);
      send_force(16'sh7fff);
      send_force(16'sh8000);
      send_force(16'sd301);
      send_force(-16'sd301);

      // half-way rounding goes toward plus infinity; widest clamps, top baseline
      set_filter(32'sh0080_0000, '0, '0, '0, '0, 16'sh8000, 16'sh7fff, 24'sh7fffff);
      send_force(16'sd1);
      send_force(-16'sd1);
      send_force(16'sd3);
      send_force(-16'sd3);
      send_force(16'sh8000);
      send_force(16'sh7fff);

      // overlapping clamps: saturation wins over baseline
      set_filter(32'sh7fff_ffff, 32'sh8000_0000, '0, '0, '0, 16'sd100, 16'sd50, 24'sh800000);
      send_force(16'sd75);
      send_force(16'sd50);
      send_force(16'sd40);

      // output saturation at both ends through large feedback
      set_filter(32'sh7fff_ffff, 32'sh7fff_ffff, '0, 32'sh7fff_ffff, '0,
                 16'sh8000, 16'sh7fff, '0);
      send_force(16'sd32766);
      send_force(16'sd32766);
      send_force(-16'sd32767);

      // random phases over several register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_filter(small_coef(1 << 25), small_coef(1 << 25), small_coef(1 << 25),
                          small_coef(1 << 24), small_coef(1 << 23),
                          -16'sd16384, 16'sd16384, 24'($urandom));
            1: set_filter($urandom, $urandom, $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), 24'($urandom));
            2: set_filter(small_coef(1 << 24), small_coef(1 << 24), small_coef(1 << 24),
                          32'sh7fff_ffff, 32'sh8000_0000, 16'sh8000, 16'sh7fff, 24'sh7fffff);
            3: set_filter(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh8000_0000, 32'sh8000_0000,
                          16'(-int'($urandom_range(0, 32768))),
                          16'($urandom_range(0, 32767)), 24'sh800000);
            4: begin : narrow
               int t;
               t = int'($urandom_range(0, 65000)) - 32768;
               set_filter(small_coef(1 << 25), small_coef(1 << 25), small_coef(1 << 25),
                          small_coef(1 << 24), small_coef(1 << 23),
                          16'(t), 16'(t + int'($urandom_range(2, 600))), 24'($urandom));
            end
            default: set_filter(small_coef(1 << 26), small_coef(1 << 26), small_coef(1 << 26),
                                small_coef(1 << 24), small_coef(1 << 23),
                                16'sh8000, 16'sh7fff, '0);
         endcase
         repeat (PHASE_ITEMS) send_force(pick_force());
      end

      // drain and verdict
      wait_idle();
      if (fail_count == 0 && rates_pending == 0)
         $display("clamped_second_order_iir_rate verification clean");
      else
         $display("clamped_second_order_iir_rate verification failed");
      $finish;
   end

endmodule

FILE: clamped_second_order_iir_rate.f
+incdir+hdl
hdl/csoir_pkg.sv
hdl/csoir_csr.sv
hdl/csoir_front.sv
hdl/csoir_cmd_queue.sv
hdl/csoir_back.sv
hdl/clamped_second_order_iir_rate.sv
sim/clamped_second_order_iir_rate_checker.sv
sim/clamped_second_order_iir_rate_test.sv
